>>> design/plog_pkg.sv
// Shared types and constants for the ping-pong sample logger.
// Used by plog_setup, ping_pong_sample_logger and the testbench; no dependencies.
package plog_pkg;

	// Input item kinds, carried on the slave-side tuser.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_ACK   = 2'd2
	} op_t;

	// Configuration register indexes.
	localparam logic CFG_SAMPLE_RATE = 1'b0;
	localparam logic CFG_RECORD_MS   = 1'b1;

	// Field widths fixed by the interface.
	localparam int RATE_W   = 14;
	localparam int LENMS_W  = 32;
	localparam int INDEX_W  = 14;
	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 32;
	localparam int PROD_W   = LENMS_W + RATE_W;
	// Scaled sample counter holds 1000 * (count + 1), at most 1000 * 2^32.
	localparam int SCALED_W = 42;

	// Reset values of the configuration registers.
	localparam logic [RATE_W-1:0]  RATE_RESET  = 14'd1000;
	localparam logic [LENMS_W-1:0] LENMS_RESET = 32'd0;

	// Blocks per second when the rate divides evenly.
	localparam int BLOCK_DIV = 50;
	// Reciprocal of 50 scaled by 2^18; exact for every 14-bit rate.
	localparam int RECIP_SHIFT = 18;
	localparam logic [12:0] RECIP_50 = 13'd5243;
	localparam int RPROD_W = 27;
	localparam int QUOT_W = 9;
	localparam int MULT_W = 15;

	// Milliseconds per second, in the width of the scaled counter.
	localparam logic [SCALED_W-1:0] MS_PER_S = 42'd1000;

	// Recording setup derived from the registers at a start item.
	typedef struct packed {
		logic [INDEX_W-1:0] block_words;
		logic [PROD_W-1:0]  target_scaled;
	} setup_t;

endpackage

>>> design/ping_pong_sample_logger.sv
// Ping-pong sample logger: logs sample words into two alternating banks.
// Each accepted item passes the input register, then the result register.
// Throughput: one item per cycle while results are taken; every item gives
// exactly one result. A stalled result holds the input stage, which then takes
// at most one more item. Reset (arst_n low) halts the logger and clears its
// flags and counters but the scaled counter, which it sets to 1000, and it sets
// the rate register to 1000 and the length register to 0.
module ping_pong_sample_logger
	import plog_pkg::*;
#(
	parameter int BANK_WORDS = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write port.
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [LENMS_W-1:0]  cfg_data,
	// Input stream.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,  // [31:0] sample
	input  logic [1:0]          s_tuser,  // [1:0] op
	// Result stream.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [55:0]         m_tdata,  // [0] write_bank, [14:1] write_index,
	                                      // [46:15] write_data, [47] ready_bank,
	                                      // [48] data_ready, [49] running,
	                                      // [50] finished, [55:51] zero
	output logic                m_tuser,  // [0] write_valid
	output logic                m_tlast   // block_done
);

	// Configuration registers.
	logic [RATE_W-1:0]   rate_q;
	logic [LENMS_W-1:0]  length_ms_q;

	// Input stage.
	logic                valid_s1;
	logic [1:0]          op_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// Logger state.
	logic                active_q;
	logic                ready_flag_q;
	logic                cur_bank_q;
	logic                last_bank_q;
	logic [INDEX_W-1:0]  word_pos_q;
	logic [INDEX_W-1:0]  block_words_q;
	logic [COUNT_W-1:0]  samples_done_q;
	logic [SCALED_W-1:0] scaled_done_q;
	logic [PROD_W-1:0]   target_q;

	// Result register.
	logic                out_valid_q;
	logic                wv_q, wb_q, done_q, rbank_q, rdy_q, run_q, fin_q;
	logic [INDEX_W-1:0]  wi_q;
	logic [SAMPLE_W-1:0] wd_q;

	// Next values.
	logic                advance;
	logic                active_d, ready_flag_d, cur_bank_d, last_bank_d;
	logic [INDEX_W-1:0]  word_pos_d, block_words_d;
	logic [COUNT_W-1:0]  samples_done_d;
	logic [SCALED_W-1:0] scaled_done_d;
	logic [PROD_W-1:0]   target_d;
	logic                wv_d, wb_d, done_d, fin_d;
	logic [INDEX_W-1:0]  wi_d;
	logic [SAMPLE_W-1:0] wd_d;
	logic [INDEX_W-1:0]  last_pos;
	logic                more_samples;
	setup_t              setup;

	plog_setup #(
		.BANK_WORDS (BANK_WORDS)
	) u_setup (
		.rate      (rate_q),
		.length_ms (length_ms_q),
		.setup     (setup)
	);

	// Handshake: the stage moves when the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= RATE_RESET;
			length_ms_q <= LENMS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLE_RATE: rate_q      <= cfg_data[RATE_W-1:0];
				CFG_RECORD_MS:   length_ms_q <= cfg_data;
				default:         rate_q      <= rate_q;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= s_tuser;
			sample_s1 <= s_tdata;
		end
	end

	// A sample may be stored while 1000 * (count + 1) <= length_ms * rate,
	// which is count < floor(length_ms * rate / 1000), and the count
	// saturates at its all-ones value.
	assign more_samples = (PROD_W'(scaled_done_q) <= target_q) && (samples_done_q != '1);
	assign last_pos     = (block_words_q == '0) ? '0 : block_words_q - INDEX_W'(1);

	// Per-item state update and result.
	always_comb begin
		active_d       = active_q;
		ready_flag_d   = ready_flag_q;
		cur_bank_d     = cur_bank_q;
		last_bank_d    = last_bank_q;
		word_pos_d     = word_pos_q;
		block_words_d  = block_words_q;
		samples_done_d = samples_done_q;
		scaled_done_d  = scaled_done_q;
		target_d       = target_q;
		wv_d           = 1'b0;
		wb_d           = 1'b0;
		wi_d           = '0;
		wd_d           = '0;
		done_d         = 1'b0;
		fin_d          = 1'b0;
		unique case (op_s1)
			OP_START: begin
				block_words_d  = setup.block_words;
				target_d       = setup.target_scaled;
				samples_done_d = '0;
				scaled_done_d  = MS_PER_S;
				word_pos_d     = '0;
				ready_flag_d   = 1'b0;
				active_d       = 1'b1;
			end
			OP_TICK: begin
				if (active_q && more_samples) begin
					wv_d           = 1'b1;
					wb_d           = cur_bank_q;
					wi_d           = word_pos_q;
					wd_d           = sample_s1;
					samples_done_d = samples_done_q + COUNT_W'(1);
					scaled_done_d  = scaled_done_q + MS_PER_S;
					if (word_pos_q >= last_pos) begin
						last_bank_d  = cur_bank_q;
						ready_flag_d = 1'b1;
						word_pos_d   = '0;
						cur_bank_d   = !cur_bank_q;
						done_d       = 1'b1;
					end else begin
						word_pos_d = word_pos_q + INDEX_W'(1);
					end
				end else if (active_q) begin
					samples_done_d = '0;
					scaled_done_d  = MS_PER_S;
					word_pos_d     = '0;
					active_d       = 1'b0;
					fin_d          = 1'b1;
				end
			end
			OP_ACK: begin
				ready_flag_d = 1'b0;
			end
			default: begin
				// Unused code: status report only.
				active_d = active_q;
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			ready_flag_q   <= 1'b0;
			cur_bank_q     <= 1'b0;
			last_bank_q    <= 1'b0;
			word_pos_q     <= '0;
			block_words_q  <= '0;
			samples_done_q <= '0;
			scaled_done_q  <= MS_PER_S;
			target_q       <= '0;
		end else if (advance) begin
			active_q       <= active_d;
			ready_flag_q   <= ready_flag_d;
			cur_bank_q     <= cur_bank_d;
			last_bank_q    <= last_bank_d;
			word_pos_q     <= word_pos_d;
			block_words_q  <= block_words_d;
			samples_done_q <= samples_done_d;
			scaled_done_q  <= scaled_done_d;
			target_q       <= target_d;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			wv_q    <= wv_d;
			wb_q    <= wb_d;
			wi_q    <= wi_d;
			wd_q    <= wd_d;
			done_q  <= done_d;
			rbank_q <= last_bank_d;
			rdy_q   <= ready_flag_d;
			run_q   <= active_d;
			fin_q   <= fin_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = wv_q;
	assign m_tlast  = done_q;
	assign m_tdata  = {5'b0, fin_q, run_q, rdy_q, rbank_q, wd_q, wi_q, wb_q};

	// The word position stays inside the current block while recording.
	a_pos_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && block_words_q != '0) |-> (word_pos_q < block_words_q))
		else $error("word position beyond block length");

	// The scaled counter tracks the sample count exactly.
	a_scaled_count: assert property (@(posedge clk) disable iff (!arst_n)
		scaled_done_q == (SCALED_W'(samples_done_q) * MS_PER_S + MS_PER_S))
		else $error("scaled sample counter out of step");

	// Completing a block swaps the banks and raises data-ready.
	a_block_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && done_d) |=> (cur_bank_q != $past(cur_bank_q)) && ready_flag_q
			&& (last_bank_q == $past(cur_bank_q)))
		else $error("block completion did not swap banks");

	// Storing a sample and finishing never happen on the same item.
	a_store_or_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(wv_q && fin_q))
		else $error("sample stored on the finishing tick");

endmodule

>>> design/plog_setup.sv
// Derives the block length and the scaled sample target from the registers.
// Depends on plog_pkg; instantiated by ping_pong_sample_logger.
module plog_setup
	import plog_pkg::*;
#(
	parameter int BANK_WORDS = 16384
) (
	input  logic [RATE_W-1:0]  rate,
	input  logic [LENMS_W-1:0] length_ms,
	output setup_t             setup
);

	logic [RPROD_W-1:0] recip_prod;
	logic [QUOT_W-1:0]  quot;
	logic [MULT_W-1:0]  quot_x50;
	logic               even_rate;
	logic [INDEX_W-1:0] len_raw;

	// Divide the rate by 50 through a reciprocal and check the remainder.
	assign recip_prod = RPROD_W'(rate) * RPROD_W'(RECIP_50);
	assign quot       = QUOT_W'(recip_prod >> RECIP_SHIFT);
	assign quot_x50   = MULT_W'(quot) * MULT_W'(BLOCK_DIV);
	assign even_rate  = (rate >= RATE_W'(BLOCK_DIV)) && (quot_x50 == MULT_W'(rate));
	assign len_raw    = even_rate ? INDEX_W'(quot) : rate;

	// Limit the block to one bank and compute length_ms * rate for the
	// sample target, kept unscaled so that no division by 1000 is needed.
	always_comb begin
		if (18'(len_raw) > 18'(BANK_WORDS)) begin
			setup.block_words = INDEX_W'(BANK_WORDS);
		end else begin
			setup.block_words = len_raw;
		end
		setup.target_scaled = PROD_W'(length_ms) * PROD_W'(rate);
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ping_pong_sample_logger: stream driver, result monitor
// and a cycle-free model of the logger. Depends on plog_pkg and the logger RTL.
module tb;
	import plog_pkg::*;

	localparam int LOG_BANK_WORDS = 16384;
	localparam int STALL_LIMIT = 1000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] sample;
	} log_item_t;

	typedef struct {
		logic        wr_valid;
		logic        wr_bank;
		logic [13:0] wr_index;
		logic [31:0] wr_data;
		logic        blk_done;
		logic        rdy_bank;
		logic        data_rdy;
		logic        run;
		logic        fin;
	} log_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] sample
	logic [1:0]  s_tuser = '0;   // [1:0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // [0] bank, [14:1] index, [46:15] data, [47] ready bank,
	                             // [48] data ready, [49] running, [50] finished
	logic        m_tuser;        // [0] write_valid
	logic        m_tlast;        // block_done

	log_item_t   stim_items[$];
	log_report_t expected_reports[$];
	int          mismatches = 0;
	int          stall_cycles = 0;
	int          src_gap = 0;
	int          sink_gap = 0;
	bit          bursts_on = 1'b1;
	logic        in_fired = 1'b0;

	// Logger model state and its copy of the registers.
	logic        lg_active = 1'b0;
	logic        lg_ready = 1'b0;
	logic        lg_bank = 1'b0;
	logic        lg_full_bank = 1'b0;
	logic [13:0] lg_pos = '0;
	logic [13:0] lg_words = '0;
	logic [31:0] lg_count = '0;
	logic [31:0] lg_target = '0;
	logic [13:0] lg_rate = 14'd1000;
	logic [31:0] lg_len_ms = '0;

	ping_pong_sample_logger #(
		.BANK_WORDS(LOG_BANK_WORDS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Advance the logger model by one transaction and return the status it reports.
	task automatic logger_step(input logic [1:0] op, input logic [31:0] smp,
		output log_report_t r);
		int unsigned len;
		logic [63:0] total;
		logic [13:0] last;
		r = '{default: '0};
		case (op)
			OP_START: begin
				if (lg_rate >= 50 && lg_rate % 50 == 0)
					len = lg_rate / 50;
				else
					len = lg_rate;
				if (len > LOG_BANK_WORDS)
					len = LOG_BANK_WORDS;
				lg_words = len[13:0];
				total = (64'(lg_len_ms) * 64'(lg_rate)) / 64'd1000;
				lg_target = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
				lg_count = '0;
				lg_pos = '0;
				lg_ready = 1'b0;
				lg_active = 1'b1;
			end
			OP_TICK: begin
				if (lg_active) begin
					if (lg_count < lg_target) begin
						last = (lg_words == 0) ? 14'd0 : lg_words - 14'd1;
						r.wr_valid = 1'b1;
						r.wr_bank = lg_bank;
						r.wr_index = lg_pos;
						r.wr_data = smp;
						lg_count = lg_count + 32'd1;
						if (lg_pos >= last) begin
							lg_full_bank = lg_bank;
							lg_ready = 1'b1;
							lg_pos = '0;
							lg_bank = ~lg_bank;
							r.blk_done = 1'b1;
						end else begin
							lg_pos = lg_pos + 14'd1;
						end
					end else begin
						// Tick after the last sample halts the recording.
						lg_count = '0;
						lg_pos = '0;
						lg_active = 1'b0;
						r.fin = 1'b1;
					end
				end
			end
			OP_ACK: begin
				lg_ready = 1'b0;
			end
			default: begin
			end
		endcase
		r.rdy_bank = lg_full_bank;
		r.data_rdy = lg_ready;
		r.run = lg_active;
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Source driver: presents queued transactions with random gaps between them.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fired) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (stim_items.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tuser <= stim_items[0].op;
				s_tdata <= stim_items[0].sample;
				void'(stim_items.pop_front());
				if (bursts_on && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 10);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink driver: random stall bursts on the result side.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (bursts_on && $urandom_range(0, 7) == 0)
				sink_gap = $urandom_range(1, 10);
		end
	end

	// Monitor: follows register writes, predicts accepted items, checks results.
	always @(posedge clk) begin
		log_report_t want;
		log_report_t got;
		in_fired <= s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SAMPLE_RATE: lg_rate = cfg_data[13:0];
					CFG_RECORD_MS:   lg_len_ms = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				logger_step(s_tuser, s_tdata, want);
				expected_reports.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result transaction: expected none, actual 0x%0h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					got.wr_valid = m_tuser;
					got.wr_bank = m_tdata[0];
					got.wr_index = m_tdata[14:1];
					got.wr_data = m_tdata[46:15];
					got.rdy_bank = m_tdata[47];
					got.data_rdy = m_tdata[48];
					got.run = m_tdata[49];
					got.fin = m_tdata[50];
					got.blk_done = m_tlast;
					check_field("write_valid", 32'(want.wr_valid), 32'(got.wr_valid));
					check_field("write_bank", 32'(want.wr_bank), 32'(got.wr_bank));
					check_field("write_index", 32'(want.wr_index), 32'(got.wr_index));
					check_field("write_data", want.wr_data, got.wr_data);
					check_field("block_done", 32'(want.blk_done), 32'(got.blk_done));
					check_field("ready_bank", 32'(want.rdy_bank), 32'(got.rdy_bank));
					check_field("data_ready", 32'(want.data_rdy), 32'(got.data_rdy));
					check_field("running", 32'(want.run), 32'(got.run));
					check_field("finished", 32'(want.fin), 32'(got.fin));
				end
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [31:0] smp);
		log_item_t it;
		it.op = op;
		it.sample = smp;
		stim_items.push_back(it);
	endtask

	// Wait until every item is accepted and every result has come back.
	task automatic wait_drained();
		while (stim_items.size() != 0 || s_tvalid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One recording session: fresh registers, usually a start, and mostly ticks.
	task automatic random_session(output int count);
		int unsigned rate;
		int unsigned ms;
		int unsigned tgt;
		int n;
		int pick;
		case ($urandom_range(0, 9))
			0: rate = ($urandom_range(0, 3) == 0) ? 0 : 1;
			1: rate = 10000;
			2: rate = $urandom_range(1, 10000);
			3, 4, 5, 6: rate = 50 * $urandom_range(1, 10);
			default: rate = $urandom_range(2, 16);
		endcase
		case ($urandom_range(0, 9))
			0: ms = 0;
			1: ms = 32'hFFFF_FFFF;
			2: ms = $urandom;
			default: begin
				tgt = $urandom_range(1, 40);
				ms = (rate == 0) ? $urandom : (tgt * 1000 + rate - 1) / rate;
			end
		endcase
		write_reg(CFG_SAMPLE_RATE, rate);
		write_reg(CFG_RECORD_MS, ms);
		// Now and then leave out the start to hit a halted or carried-over logger.
		count = 0;
		if ($urandom_range(0, 5) != 0) begin
			push_item(OP_START, $urandom);
			count++;
		end
		n = $urandom_range(15, 45);
		repeat (n) begin
			pick = $urandom_range(0, 19);
			case (pick)
				0: push_item(OP_START, $urandom);
				1, 2: push_item(OP_ACK, $urandom);
				3: push_item(OP_UNUSED, $urandom);
				4: push_item(2'($urandom_range(0, 3)), $urandom);
				default: push_item(OP_TICK, $urandom);
			endcase
		end
		count += n;
		wait_drained();
	endtask

	initial begin
		int done_items;
		int got;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Halted logger with reset registers: ignored tick, idle acknowledge,
		// unused code, then a start with a zero sample count.
		push_item(OP_TICK, 32'hFFFF_FFFF);
		push_item(OP_ACK, 32'h0);
		push_item(OP_UNUSED, 32'h0);
		push_item(OP_START, 32'h0);
		push_item(OP_TICK, 32'h0);
		push_item(OP_TICK, 32'h1234_5678);
		wait_drained();

		// Rate of zero gives a zero block length.
		write_reg(CFG_SAMPLE_RATE, 32'd0);
		write_reg(CFG_RECORD_MS, 32'd12345);
		push_item(OP_START, 32'h0);
		push_item(OP_TICK, 32'hFFFF_FFFF);
		wait_drained();

		// One-word blocks: every tick swaps banks; restart keeps the bank.
		write_reg(CFG_SAMPLE_RATE, 32'd50);
		write_reg(CFG_RECORD_MS, 32'd100000);
		push_item(OP_START, 32'h0);
		push_item(OP_TICK, 32'hFFFF_FFFF);
		push_item(OP_TICK, 32'h0);
		push_item(OP_ACK, 32'h0);
		push_item(OP_TICK, 32'hA5A5_A5A5);
		push_item(OP_START, 32'h0);
		push_item(OP_TICK, 32'h5A5A_5A5A);
		push_item(OP_ACK, 32'h0);
		push_item(OP_ACK, 32'h0);
		wait_drained();

		// Highest rate with the longest duration gives a sample target beyond the 32-bit count range.
		write_reg(CFG_SAMPLE_RATE, 32'd10000);
		write_reg(CFG_RECORD_MS, 32'hFFFF_FFFF);
		push_item(OP_START, 32'h0);
		push_item(OP_TICK, 32'h8000_0001);
		push_item(OP_TICK, 32'h7FFF_FFFE);
		wait_drained();

		// Rate not a multiple of 50: block equals the rate, then the halt.
		write_reg(CFG_SAMPLE_RATE, 32'd3);
		write_reg(CFG_RECORD_MS, 32'd1000);
		push_item(OP_START, 32'h0);
		repeat (4) push_item(OP_TICK, $urandom);
		wait_drained();

		// Random sessions; the last stretch runs without any idling.
		done_items = 0;
		while (done_items < 430) begin
			if (done_items > 340)
				bursts_on = 1'b0;
			random_session(got);
			done_items += got;
		end

		wait_drained();
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
